// ----- design/bpp_pkg.sv -----
// ----------------------------------------------------------------------------
// bpp_pkg: shared types and constants for the box particle pushout unit
// Fixed-point widths, transform row unpacking, saturation and code values.
// ----------------------------------------------------------------------------
package bpp_pkg;

   // Q8.8 position, Q4.12 coefficient, Q4.12 normal
   typedef logic signed [15:0] coord_type;
   // One packed transform row: three Q4.12 coefficients, Q8.8 translation
   typedef logic [63:0]        row_type;
   // Local coordinate with 20 fraction bits, full range
   typedef logic signed [32:0] loc_type;
   // Local coordinate once the point is known to be inside the box
   typedef logic signed [20:0] ploc_type;
   // Distance from a local coordinate to a face
   typedef logic signed [21:0] dist_type;
   // Forward accumulator with 32 fraction bits
   typedef logic signed [40:0] acc_type;

   // Configuration register indexes
   localparam logic [2:0] REG_FWD_X = 3'd0;
   localparam logic [2:0] REG_FWD_Y = 3'd1;
   localparam logic [2:0] REG_FWD_Z = 3'd2;
   localparam logic [2:0] REG_INV_X = 3'd3;
   localparam logic [2:0] REG_INV_Y = 3'd4;
   localparam logic [2:0] REG_INV_Z = 3'd5;

   // Identity rows after reset
   localparam row_type ROW_X_RESET = 64'h0000_0000_0000_1000;
   localparam row_type ROW_Y_RESET = 64'h0000_0000_1000_0000;
   localparam row_type ROW_Z_RESET = 64'h0000_1000_0000_0000;

   // Face codes in priority order; bits [2:1] give the axis, bit 0 the sign
   localparam logic [2:0] FACE_PX = 3'd0;
   localparam logic [2:0] FACE_NX = 3'd1;
   localparam logic [2:0] FACE_PY = 3'd2;
   localparam logic [2:0] FACE_NY = 3'd3;
   localparam logic [2:0] FACE_PZ = 3'd4;
   localparam logic [2:0] FACE_NZ = 3'd5;

   localparam logic [1:0] AXIS_Z = 2'd2;

   // Box half extent 0.5 and pushout distance 0.6, both with 20 fraction bits
   localparam loc_type  LOC_HALF   = 33'sd524288;
   localparam dist_type DIST_HALF  = 22'sd524288;
   localparam ploc_type PUSH_POS   = 21'sd629146;
   localparam ploc_type PUSH_NEG   = -21'sd629146;
   // Half an output LSB at 32 fraction bits
   localparam acc_type  ACC_ROUND  = 41'sd8388608;

   // Pick field k of a packed row (0..2 coefficients, 3 translation)
   function automatic coord_type row_field(row_type row, logic [1:0] k);
      return coord_type'(row[{k, 4'b0000} +: 16]);
   endfunction

   // Clamp a 17-bit signed value into 16 bits
   function automatic coord_type sat17(logic signed [16:0] v);
      coord_type r;
      if (v > 17'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -17'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = coord_type'(v[15:0]);
      end
      return r;
   endfunction

   // Local point after the inverse transform
   typedef struct packed {
      coord_type [2:0] pos;
      loc_type   [2:0] loc;
   } loc_stage_type;

   // Pushed local point and face decision
   typedef struct packed {
      coord_type [2:0] pos;
      ploc_type  [2:0] ploc;
      logic      [1:0] axis;
      logic            neg;
      logic            hit;
   } face_stage_type;

   // Final result item
   typedef struct packed {
      coord_type [2:0] out;
      coord_type [2:0] vel;
      logic            hit;
   } rsp_data_type;

endpackage

// ----- design/bpp_if.sv -----
// ----------------------------------------------------------------------------
// bpp_if: request and response channels of the box particle pushout unit
// Valid/ready channels; one transfer when valid and ready are both high.
// ----------------------------------------------------------------------------
interface bpp_req_if import bpp_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type pos_x;
   coord_type pos_y;
   coord_type pos_z;

   modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
   modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

interface bpp_rsp_if import bpp_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type out_x;
   coord_type out_y;
   coord_type out_z;
   coord_type vel_x;
   coord_type vel_y;
   coord_type vel_z;
   logic      hit;

   modport source (output valid, output out_x, output out_y, output out_z,
                   output vel_x, output vel_y, output vel_z, output hit, input ready);
   modport sink   (input valid, input out_x, input out_y, input out_z,
                   input vel_x, input vel_y, input vel_z, input hit, output ready);
endinterface

// ----- design/bpp_inv_xform.sv -----
// ----------------------------------------------------------------------------
// bpp_inv_xform: world to local mapping
// Two stages: nine coefficient products, then row sums plus translation.
// ----------------------------------------------------------------------------
module bpp_inv_xform import bpp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  coord_type [2:0] in_pos,
   input  row_type   [2:0] inv_rows,
   output logic            out_valid,
   input  logic            out_ready,
   output loc_stage_type   out_data
);

   logic signed [31:0] prod_in [3][3];
   logic signed [31:0] prod_ff [3][3];
   coord_type          trans_ff [3];
   coord_type [2:0]    pos1_ff;
   logic               v1_ff;
   logic               s2_ready;

   loc_stage_type      s2_in;
   loc_stage_type      s2_ff;
   logic               v2_ff;

   // Stage readiness: a stage takes data when empty or when it drains
   assign s2_ready = !v2_ff || out_ready;
   assign in_ready = !v1_ff || s2_ready;

   // Stage 1 products
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            prod_in[i][j] = 32'(row_field(inv_rows[i], 2'(j))) * 32'($signed(in_pos[j]));
         end
      end
   end

   // Stage 2 row sums with translation scaled to 20 fraction bits
   always_comb begin
      s2_in.pos = pos1_ff;
      for (int i = 0; i < 3; i++) begin
         s2_in.loc[i] = 33'(prod_ff[i][0]) + 33'(prod_ff[i][1]) + 33'(prod_ff[i][2])
                      + 33'($signed({trans_ff[i], 12'b0}));
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            v1_ff <= in_valid;
         end
         if (s2_ready) begin
            v2_ff <= v1_ff;
         end
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (in_ready) begin
         prod_ff <= prod_in;
         pos1_ff <= in_pos;
         for (int i = 0; i < 3; i++) begin
            trans_ff[i] <= row_field(inv_rows[i], 2'd3);
         end
      end
      if (s2_ready) begin
         s2_ff <= s2_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_data  = s2_ff;

endmodule

// ----- design/bpp_face_sel.sv -----
// ----------------------------------------------------------------------------
// bpp_face_sel: inside test and nearest face choice
// One stage: box test, six face distances, pushout of the chosen axis.
// ----------------------------------------------------------------------------
module bpp_face_sel import bpp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  loc_stage_type  in_data,
   output logic           out_valid,
   input  logic           out_ready,
   output face_stage_type out_data
);

   logic           in_box;
   ploc_type [2:0] short_loc;
   dist_type       face_gap [6];
   dist_type       best;
   logic [2:0]     face;
   face_stage_type s3_in;
   face_stage_type s3_ff;
   logic           v3_ff;

   assign in_ready = !v3_ff || out_ready;

   // Box test on the full-width local coordinates
   always_comb begin
      in_box = 1'b1;
      for (int i = 0; i < 3; i++) begin
         if (!($signed(in_data.loc[i]) < LOC_HALF && $signed(in_data.loc[i]) > -LOC_HALF)) begin
            in_box = 1'b0;
         end
         short_loc[i] = ploc_type'(in_data.loc[i][20:0]);
      end
   end

   // Face distances; only meaningful once the point is inside
   always_comb begin
      for (int f = 0; f < 6; f++) begin
         if (f % 2 == 1) begin
            face_gap[f] = 22'($signed(short_loc[f / 2])) + DIST_HALF;
         end else begin
            face_gap[f] = DIST_HALF - 22'($signed(short_loc[f / 2]));
         end
      end
   end

   // Nearest face; strict compare keeps the earlier face on a tie
   always_comb begin
      best = face_gap[0];
      face = FACE_PX;
      for (int f = 1; f < 6; f++) begin
         if (face_gap[f] < best) begin
            best = face_gap[f];
            face = 3'(f);
         end
      end
   end

   // Replace the chosen coordinate with the pushout distance
   always_comb begin
      s3_in.pos  = in_data.pos;
      s3_in.axis = face[2:1];
      s3_in.neg  = face[0];
      s3_in.hit  = in_box;
      for (int i = 0; i < 3; i++) begin
         if (face[2:1] == 2'(i)) begin
            s3_in.ploc[i] = face[0] ? PUSH_NEG : PUSH_POS;
         end else begin
            s3_in.ploc[i] = short_loc[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (in_ready) begin
         v3_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         s3_ff <= s3_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_data  = s3_ff;

   // A hit always names a real axis
   a_hit_axis: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_data.hit |-> out_data.axis <= AXIS_Z)
      else $error("pushout axis out of range");

endmodule

// ----- design/bpp_fwd_xform.sv -----
// ----------------------------------------------------------------------------
// bpp_fwd_xform: local to world mapping and result assembly
// Two stages: products and normal pick, then sums, rounding and saturation.
// ----------------------------------------------------------------------------
module bpp_fwd_xform import bpp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  face_stage_type in_data,
   input  row_type [2:0]  fwd_rows,
   output logic           out_valid,
   input  logic           out_ready,
   output rsp_data_type   out_data
);

   logic signed [36:0] prod_in [3][3];
   logic signed [36:0] prod_ff [3][3];
   coord_type          trans_ff [3];
   coord_type [2:0]    vel_in;
   coord_type [2:0]    vel_ff;
   coord_type [2:0]    pos4_ff;
   logic               hit4_ff;
   logic               v4_ff;
   logic               s5_ready;

   acc_type            acc [3];
   rsp_data_type       s5_in;
   rsp_data_type       s5_ff;
   logic               v5_ff;

   assign s5_ready = !v5_ff || out_ready;
   assign in_ready = !v4_ff || s5_ready;

   // Stage 4 products and face normal
   always_comb begin
      coord_type c;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            prod_in[i][j] = 37'(row_field(fwd_rows[i], 2'(j))) * 37'($signed(in_data.ploc[j]));
         end
         c = row_field(fwd_rows[i], in_data.axis);
         if (!in_data.hit) begin
            vel_in[i] = '0;
         end else if (in_data.neg) begin
            vel_in[i] = sat17(-17'(c));
         end else begin
            vel_in[i] = c;
         end
      end
   end

   // Stage 5 sums, round to Q8.8 with floor shift, saturate on a hit
   always_comb begin
      s5_in.vel = vel_ff;
      s5_in.hit = hit4_ff;
      for (int i = 0; i < 3; i++) begin
         acc[i] = 41'(prod_ff[i][0]) + 41'(prod_ff[i][1]) + 41'(prod_ff[i][2])
                + 41'($signed({trans_ff[i], 24'b0})) + ACC_ROUND;
         s5_in.out[i] = hit4_ff ? sat17(acc[i][40:24]) : pos4_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            v4_ff <= in_valid;
         end
         if (s5_ready) begin
            v5_ff <= v4_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         prod_ff <= prod_in;
         vel_ff  <= vel_in;
         pos4_ff <= in_data.pos;
         hit4_ff <= in_data.hit;
         for (int i = 0; i < 3; i++) begin
            trans_ff[i] <= row_field(fwd_rows[i], 2'd3);
         end
      end
      if (s5_ready) begin
         s5_ff <= s5_in;
      end
   end

   assign out_valid = v5_ff;
   assign out_data  = s5_ff;

endmodule

// ----- design/box_particle_pushout_unit.sv -----
// Throughput: one particle per cycle while responses are taken; five
// register stages (two inverse, one face select, two forward) each hold
// one item, keep it on a stall and pass it on in order to the response.
// Reset: synchronous; clears all stage valid bits and loads identity rows
// into both transforms. Result payload registers are not reset.
// ----------------------------------------------------------------------------
// box_particle_pushout_unit: top level
// Pushes particles out of an affinely placed unit box; holds the six
// transform rows written through the CSR port.
// ----------------------------------------------------------------------------
module box_particle_pushout_unit import bpp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   bpp_req_if.sink     req_ch,
   bpp_rsp_if.source   rsp_ch,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   row_type [2:0]  fwd_rows_ff;
   row_type [2:0]  inv_rows_ff;
   coord_type [2:0] req_pos;

   logic           loc_valid;
   logic           loc_ready;
   loc_stage_type  loc_data;
   logic           face_valid;
   logic           face_ready;
   face_stage_type face_data;
   rsp_data_type   rsp_data;

   // Transform rows; out-of-range indexes drop the write
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_rows_ff[0] <= ROW_X_RESET;
         fwd_rows_ff[1] <= ROW_Y_RESET;
         fwd_rows_ff[2] <= ROW_Z_RESET;
         inv_rows_ff[0] <= ROW_X_RESET;
         inv_rows_ff[1] <= ROW_Y_RESET;
         inv_rows_ff[2] <= ROW_Z_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_FWD_X: fwd_rows_ff[0] <= csr_wdata;
            REG_FWD_Y: fwd_rows_ff[1] <= csr_wdata;
            REG_FWD_Z: fwd_rows_ff[2] <= csr_wdata;
            REG_INV_X: inv_rows_ff[0] <= csr_wdata;
            REG_INV_Y: inv_rows_ff[1] <= csr_wdata;
            REG_INV_Z: inv_rows_ff[2] <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign req_pos[0] = req_ch.pos_x;
   assign req_pos[1] = req_ch.pos_y;
   assign req_pos[2] = req_ch.pos_z;

   bpp_inv_xform u_inv (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .in_pos    (req_pos),
      .inv_rows  (inv_rows_ff),
      .out_valid (loc_valid),
      .out_ready (loc_ready),
      .out_data  (loc_data)
   );

   bpp_face_sel u_face (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (loc_valid),
      .in_ready  (loc_ready),
      .in_data   (loc_data),
      .out_valid (face_valid),
      .out_ready (face_ready),
      .out_data  (face_data)
   );

   bpp_fwd_xform u_fwd (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (face_valid),
      .in_ready  (face_ready),
      .in_data   (face_data),
      .fwd_rows  (fwd_rows_ff),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_data  (rsp_data)
   );

   // Drive the response fields
   assign rsp_ch.out_x = rsp_data.out[0];
   assign rsp_ch.out_y = rsp_data.out[1];
   assign rsp_ch.out_z = rsp_data.out[2];
   assign rsp_ch.vel_x = rsp_data.vel[0];
   assign rsp_ch.vel_y = rsp_data.vel[1];
   assign rsp_ch.vel_z = rsp_data.vel[2];
   assign rsp_ch.hit   = rsp_data.hit;

   // A miss carries no pushout direction
   a_miss_zero_vel: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.hit |->
         rsp_ch.vel_x == '0 && rsp_ch.vel_y == '0 && rsp_ch.vel_z == '0)
      else $error("nonzero velocity on a miss");

   // A draining or empty output stage lets the whole pipe take a request
   a_pipe_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.ready || !rsp_ch.valid |-> req_ch.ready)
      else $error("request stalled with free output stage");

   // A row write lands in the addressed register
   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en && csr_index == REG_INV_X |=> inv_rows_ff[0] == $past(csr_wdata))
      else $error("inverse row write lost");

endmodule

// ----- test/pushout_check_pkg.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pushout_check_pkg: expected-result tracking for the box pushout unit
// Keeps a private copy of both transforms, computes the pushed position,
// normal and hit flag per particle, and compares them in order against the
// responses that come out of the unit.
// ----------------------------------------------------------------------------
package pushout_check_pkg;
   import bpp_pkg::*;

   // Box half extent and pushout distance, 20 fraction bits
   localparam longint HALF_Q20     = 524288;
   localparam longint PUSH_Q20     = 629146;
   // Half an output LSB at 32 fraction bits
   localparam longint ROUND_Q32    = 8388608;
   localparam longint TRANS_Q12    = 4096;
   localparam longint TRANS_Q24    = 16777216;
   localparam int     REPORT_LIMIT = 10;

   class pushout_scoreboard;
      row_type      fwd_rows[3];
      row_type      inv_rows[3];
      rsp_data_type queued_pushouts[$];
      int           particles;
      int           pushouts;
      int           fault_count;
      int           face_hits[6];

      function new();
         fwd_rows[0] = ROW_X_RESET;
         fwd_rows[1] = ROW_Y_RESET;
         fwd_rows[2] = ROW_Z_RESET;
         inv_rows    = fwd_rows;
         particles   = 0;
         pushouts    = 0;
         fault_count = 0;
         foreach (face_hits[f]) face_hits[f] = 0;
      endfunction

      // Mirror a register write; indexes past the inverse rows are dropped
      function void set_row(logic [2:0] index, row_type value);
         if (index <= REG_FWD_Z) begin
            fwd_rows[index] = value;
         end else if (index <= REG_INV_Z) begin
            inv_rows[index - REG_INV_X] = value;
         end
      endfunction

      // Signed 16-bit field k of a packed row (3 is the translation)
      function longint row_term(row_type row, int k);
         logic signed [15:0] f;
         f = row[16*k +: 16];
         return longint'(f);
      endfunction

      function coord_type clamp16(longint v);
         if (v > 32767) return 16'sh7FFF;
         if (v < -32768) return 16'sh8000;
         return v[15:0];
      endfunction

      // Push one particle out of the box; face is -1 when nothing is hit
      function rsp_data_type predict_pushout(coord_type x, coord_type y, coord_type z,
                                             output int face);
         longint       p[3];
         longint       lc[3];
         longint       acc;
         longint       gap;
         longint       best;
         longint       coef;
         int           axis;
         bit           neg;
         bit           in_box;
         rsp_data_type r;
         p[0]   = x;
         p[1]   = y;
         p[2]   = z;
         in_box = 1'b1;
         face   = -1;
         // world to local, exact with 20 fraction bits
         for (int i = 0; i < 3; i++) begin
            acc = row_term(inv_rows[i], 3) * TRANS_Q12;
            for (int j = 0; j < 3; j++) acc += row_term(inv_rows[i], j) * p[j];
            lc[i] = acc;
            if (!(acc < HALF_Q20 && acc > -HALF_Q20)) in_box = 1'b0;
         end
         // on a face or outside: pass through
         if (!in_box) begin
            r.out[0] = x;
            r.out[1] = y;
            r.out[2] = z;
            for (int i = 0; i < 3; i++) r.vel[i] = '0;
            r.hit = 1'b0;
            return r;
         end
         // nearest face; the earlier face keeps a tie
         best = 0;
         for (int f = 0; f < 6; f++) begin
            gap = (f % 2 == 1) ? lc[f / 2] + HALF_Q20 : HALF_Q20 - lc[f / 2];
            if (f == FACE_PX || gap < best) begin
               best = gap;
               face = f;
            end
         end
         axis     = face / 2;
         neg      = (face % 2 == 1);
         lc[axis] = neg ? -PUSH_Q20 : PUSH_Q20;
         // local to world, round to Q8.8, normal from the forward column
         for (int i = 0; i < 3; i++) begin
            acc = row_term(fwd_rows[i], 3) * TRANS_Q24;
            for (int j = 0; j < 3; j++) acc += row_term(fwd_rows[i], j) * lc[j];
            r.out[i] = clamp16((acc + ROUND_Q32) >>> 24);
            coef     = row_term(fwd_rows[i], axis);
            r.vel[i] = clamp16(neg ? -coef : coef);
         end
         r.hit = 1'b1;
         return r;
      endfunction

      // Queue the expected response of an accepted particle
      function void note_particle(coord_type x, coord_type y, coord_type z);
         rsp_data_type r;
         int           face;
         r = predict_pushout(x, y, z, face);
         particles++;
         if (face >= 0) begin
            pushouts++;
            face_hits[face]++;
         end
         queued_pushouts = {queued_pushouts, r};
      endfunction

      // Compare a response transfer with the oldest queued expectation
      function void check_result(rsp_data_type got);
         rsp_data_type want;
         bit           bad;
         if (queued_pushouts.size() == 0) begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT) begin
               $display("response with no particle outstanding: out=(%0d,%0d,%0d) hit=%0d",
                        got.out[0], got.out[1], got.out[2], got.hit);
            end
            return;
         end
         want = queued_pushouts.pop_front();
         bad  = (got.hit !== want.hit);
         for (int i = 0; i < 3; i++) begin
            if (got.out[i] !== want.out[i] || got.vel[i] !== want.vel[i]) bad = 1'b1;
         end
         if (bad) begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT) begin
               $display("response %0d: expected out=(%0d,%0d,%0d) vel=(%0d,%0d,%0d) hit=%0d",
                        particles - queued_pushouts.size() - 1,
                        want.out[0], want.out[1], want.out[2],
                        want.vel[0], want.vel[1], want.vel[2], want.hit);
               $display("   actual out=(%0d,%0d,%0d) vel=(%0d,%0d,%0d) hit=%0d",
                        got.out[0], got.out[1], got.out[2],
                        got.vel[0], got.vel[1], got.vel[2], got.hit);
            end
         end
      endfunction

      function int pending();
         return queued_pushouts.size();
      endfunction
   endclass

endpackage

// ----- test/tb_box_particle_pushout_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_box_particle_pushout_unit: self-checking bench for the pushout unit
// Streams particles through the unit under several transform settings,
// with random gaps on both channels, and checks every response in order.
// ----------------------------------------------------------------------------
module tb_box_particle_pushout_unit;
   import bpp_pkg::*;
   import pushout_check_pkg::*;

   localparam int         HALF_PERIOD  = 5;
   localparam int         RESET_CYCLES = 5;
   localparam int         IDLE_PERCENT = 19;
   localparam int         WIDE_PERCENT = 20;
   localparam int         PHASE_ITEMS  = 200;
   localparam int         STEADY_ITEMS = 150;
   localparam int         DRAIN_CYCLES = 10;
   localparam int         CYCLE_LIMIT  = 400000;
   // Indexes past the last register; writes there must be ignored
   localparam logic [2:0] REG_SPARE_A  = 3'd6;
   localparam logic [2:0] REG_SPARE_B  = 3'd7;

   typedef enum int {
      SET_IDENTITY, SET_SCALED, SET_MODERATE, SET_EXTREME,
      SET_COLLAPSED, SET_NOISE, SET_SWAPPED, SET_DENSE, SET_COUNT
   } setting_kind;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_wr_en;
   logic [2:0]  csr_index;
   logic [63:0] csr_wdata;
   logic        steady;
   int          cycle_count = 0;
   int          settings_run = 0;
   row_type     fwd_set[3];
   row_type     inv_set[3];

   pushout_scoreboard board;

   bpp_req_if req_ch ();
   bpp_rsp_if rsp_ch ();

   box_particle_pushout_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Stall the response channel at random and check every transfer
   always @(posedge clock) begin : response_side
      rsp_data_type got;
      rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.out[0] = rsp_ch.out_x;
         got.out[1] = rsp_ch.out_y;
         got.out[2] = rsp_ch.out_z;
         got.vel[0] = rsp_ch.vel_x;
         got.vel[1] = rsp_ch.vel_y;
         got.vel[2] = rsp_ch.vel_z;
         got.hit    = rsp_ch.hit;
         board.check_result(got);
      end
   end

   function automatic int spread(int span);
      return int'($urandom_range(2 * span)) - span;
   endfunction

   function automatic coord_type near_coord(int span);
      int v;
      v = spread(span);
      return v[15:0];
   endfunction

   function automatic coord_type any_coord();
      logic [31:0] w;
      w = $urandom;
      return w[15:0];
   endfunction

   function automatic row_type pack_row(int c0, int c1, int c2, int t);
      return {t[15:0], c2[15:0], c1[15:0], c0[15:0]};
   endfunction

   function automatic row_type any_row();
      return {$urandom, $urandom};
   endfunction

   // Offer one particle, idling first at random, and hold it until taken
   task automatic send_particle(input coord_type x, input coord_type y, input coord_type z);
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.pos_x <= x;
      req_ch.pos_y <= y;
      req_ch.pos_z <= z;
      do @(posedge clock); while (!req_ch.ready);
      board.note_particle(x, y, z);
   endtask

   // Drop valid and wait until every response is back
   task automatic drain_unit();
      req_ch.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] index, input row_type value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      board.set_row(index, value);
   endtask

   // Write all six rows plus the two unused indexes
   task automatic load_transform();
      csr_write(REG_FWD_X, fwd_set[0]);
      csr_write(REG_FWD_Y, fwd_set[1]);
      csr_write(REG_FWD_Z, fwd_set[2]);
      csr_write(REG_INV_X, inv_set[0]);
      csr_write(REG_INV_Y, inv_set[1]);
      csr_write(REG_INV_Z, inv_set[2]);
      csr_write(REG_SPARE_A, any_row());
      csr_write(REG_SPARE_B, any_row());
      csr_wr_en <= 1'b0;
   endtask

   // Pick the transforms and the spread of particles for one setting
   task automatic choose_setting(input setting_kind kind, output int span);
      case (kind)
         SET_IDENTITY: begin
            fwd_set = '{ROW_X_RESET, ROW_Y_RESET, ROW_Z_RESET};
            inv_set = fwd_set;
            span    = 160;
         end
         SET_SCALED: begin
            // box half size 0.25 in the world, shrunk back on the way out
            inv_set = '{pack_row(16'h2000, 0, 0, 0), pack_row(0, 16'h2000, 0, 0),
                        pack_row(0, 0, 16'h2000, 0)};
            fwd_set = '{pack_row(16'h0800, 0, 0, spread(256)),
                        pack_row(0, 16'h0800, 0, spread(256)),
                        pack_row(0, 0, 16'h0800, spread(256))};
            span    = 100;
         end
         SET_MODERATE: begin
            foreach (inv_set[i]) begin
               inv_set[i] = pack_row(spread(16'h1800), spread(16'h1800), spread(16'h1800),
                                     spread(64));
               fwd_set[i] = pack_row(spread(32767), spread(32767), spread(32767),
                                     spread(32767));
            end
            span = 256;
         end
         SET_EXTREME: begin
            // saturating outputs; every column holds the most negative value
            inv_set = '{ROW_X_RESET, ROW_Y_RESET, ROW_Z_RESET};
            fwd_set = '{pack_row(-32768, 32767, -32768, 32767),
                        pack_row(32767, -32768, 32767, -32768),
                        pack_row(-32768, -32768, 32767, -32768)};
            span    = 127;
         end
         SET_COLLAPSED: begin
            // every point maps to the center: all faces tie
            inv_set = '{64'h0, 64'h0, 64'h0};
            foreach (fwd_set[i]) begin
               fwd_set[i] = pack_row(spread(16'h2000), spread(16'h2000), spread(16'h2000),
                                     spread(1024));
            end
            span = 32767;
         end
         SET_NOISE: begin
            foreach (inv_set[i]) begin
               inv_set[i] = any_row();
               fwd_set[i] = any_row();
            end
            span = 32767;
         end
         SET_SWAPPED: begin
            inv_set = '{pack_row(0, -4096, 0, spread(32)), pack_row(0, 0, 4096, spread(32)),
                        pack_row(4096, 0, 0, spread(32))};
            foreach (fwd_set[i]) begin
               fwd_set[i] = pack_row(spread(16'h2000), spread(16'h2000), spread(16'h2000),
                                     spread(32767));
            end
            span = 160;
         end
         default: begin
            // steepest inverse: the box is a few LSBs wide in the world
            inv_set = '{pack_row(32767, 0, 0, 0), pack_row(0, -32768, 0, 0),
                        pack_row(0, 0, 32767, 0)};
            foreach (fwd_set[i]) begin
               fwd_set[i] = pack_row(spread(32767), spread(32767), spread(32767),
                                     spread(32767));
            end
            span = 24;
         end
      endcase
   endtask

   initial begin
      int span;
      board = new();
      reset        <= 1'b1;
      csr_wr_en    <= 1'b0;
      csr_index    <= '0;
      csr_wdata    <= '0;
      steady       <= 1'b0;
      req_ch.valid <= 1'b0;
      req_ch.pos_x <= '0;
      req_ch.pos_y <= '0;
      req_ch.pos_z <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed particles against the identity transforms after reset
      send_particle(0, 0, 0);            // center: all six faces tie
      send_particle(127, 0, 0);
      send_particle(-127, 0, 0);
      send_particle(0, 100, 20);
      send_particle(0, -100, 20);
      send_particle(10, 20, 110);
      send_particle(10, 20, -110);
      send_particle(128, 0, 0);          // exactly on a face: no hit
      send_particle(-128, 0, 0);
      send_particle(0, 0, -128);
      send_particle(64, 64, 0);          // +x against +y
      send_particle(-64, 64, 0);         // -x against +y
      send_particle(0, -64, -64);        // -y against -z
      send_particle(30, -90, 90);        // -y against +z
      send_particle(127, 127, 127);
      send_particle(-127, -127, -127);
      send_particle(32767, 32767, 32767);
      send_particle(-32768, -32768, -32768);
      send_particle(32767, -32768, 0);

      // Random particles under each transform setting
      for (int s = 0; s < SET_COUNT; s++) begin
         drain_unit();
         choose_setting(setting_kind'(s), span);
         load_transform();
         settings_run++;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            steady <= (setting_kind'(s) == SET_MODERATE) && (n < STEADY_ITEMS);
            if ($urandom_range(99) < WIDE_PERCENT) begin
               send_particle(any_coord(), any_coord(), any_coord());
            end else begin
               send_particle(near_coord(span), near_coord(span), near_coord(span));
            end
         end
      end
      steady <= 1'b0;
      drain_unit();

      $display("%0d particles through %0d transform settings, %0d pushed out",
               board.particles, settings_run, board.pushouts);
      $display("faces hit: +x %0d, -x %0d, +y %0d, -y %0d, +z %0d, -z %0d",
               board.face_hits[0], board.face_hits[1], board.face_hits[2],
               board.face_hits[3], board.face_hits[4], board.face_hits[5]);
      if (board.fault_count == 0 && board.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
design/bpp_pkg.sv
design/bpp_if.sv
design/bpp_inv_xform.sv
design/bpp_face_sel.sv
design/bpp_fwd_xform.sv
design/box_particle_pushout_unit.sv
test/pushout_check_pkg.sv
test/tb_box_particle_pushout_unit.sv
